// File: design/acs_pkg.sv
package acs_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int THR_W       = 31;
   localparam int CSR_IDX_W   = 8;
   localparam int ROOT_W      = DATA_W;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int MUL_W       = PROD_W + DATA_W;
   localparam int NUM_W       = MUL_W + DATA_W;
   localparam int DEN_W       = PROD_W + FRAC_BITS;
   localparam int Q_BITS      = DATA_W + 1;
   localparam int REM_W       = DEN_W + Q_BITS;
   localparam int DIV_LAT     = Q_BITS + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA          = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_THRESHOLD = CSR_IDX_W'(1);

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] radius;
      logic signed [DATA_W-1:0] grad_x;
      logic signed [DATA_W-1:0] grad_y;
      logic signed [DATA_W-1:0] grad_z;
      logic signed [DATA_W-1:0] vel_u;
      logic signed [DATA_W-1:0] vel_v;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] mom_x;
      logic signed [DATA_W-1:0] mom_y;
      logic signed [DATA_W-1:0] energy;
      logic                     applied;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [PROD_W-1:0] a_mag;
      logic [PROD_W-1:0] b_mag;
      logic              a_neg;
      logic              b_neg;
      logic              ta_neg;
      logic              tb_neg;
      logic [DATA_W-1:0] u_mag;
      logic [DATA_W-1:0] v_mag;
      logic [DATA_W-1:0] r_mag;
      logic              r_neg;
      logic              r_zero;
   } side_type;

endpackage

// File: design/acs_mul.sv
module acs_mul (
   input  logic                         clock,
   input  logic [acs_pkg::PROD_W-1:0]   a_i,
   input  logic [acs_pkg::DATA_W-1:0]   b_i,
   output logic [acs_pkg::MUL_W-1:0]    prod_o
);

   localparam int DW = acs_pkg::DATA_W;
   localparam int PW = acs_pkg::PROD_W;
   localparam int MW = acs_pkg::MUL_W;

   logic [PW-1:0] lo_ff;
   logic [PW-1:0] hi_ff;
   logic [MW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      lo_ff   <= {{DW{1'b0}}, a_i[DW-1:0]} * {{DW{1'b0}}, b_i};
      hi_ff   <= {{DW{1'b0}}, a_i[PW-1:DW]} * {{DW{1'b0}}, b_i};
      prod_ff <= {{DW{1'b0}}, lo_ff} + {hi_ff, {DW{1'b0}}};
   end

   assign prod_o = prod_ff;

endmodule

// File: design/acs_sqrt.sv
module acs_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_i,
   input  logic [acs_pkg::RAD_W-1:0]     rad_i,
   input  acs_pkg::side_type             side_i,
   output logic                          valid_o,
   output logic [acs_pkg::ROOT_W-1:0]    root_o,
   output acs_pkg::side_type             side_o
);

   localparam int N  = acs_pkg::SQRT_STAGES;
   localparam int RW = acs_pkg::RAD_W;

   logic              valid_ff [0:N-1];
   logic [RW-1:0]     val_ff   [0:N-1];
   logic [RW-1:0]     res_ff   [0:N-1];
   acs_pkg::side_type side_ff  [0:N-1];
   logic [RW-1:0]     val_in   [0:N-1];
   logic [RW-1:0]     res_in   [0:N-1];

   always_comb begin
      logic [RW-1:0] vin;
      logic [RW-1:0] rin;
      logic [RW-1:0] bitv;
      logic [RW-1:0] trial;
      logic [RW:0]   diff;
      for (int k = 0; k < N; k++) begin
         vin   = (k == 0) ? rad_i : val_ff[(k == 0) ? 0 : k - 1];
         rin   = (k == 0) ? '0 : res_ff[(k == 0) ? 0 : k - 1];
         bitv  = RW'(1) << (RW - 2 - 2 * k);
         trial = rin + bitv;
         diff  = {1'b0, vin} - {1'b0, trial};
         if (!diff[RW]) begin
            val_in[k] = diff[RW-1:0];
            res_in[k] = (rin >> 1) + bitv;
         end else begin
            val_in[k] = vin;
            res_in[k] = rin >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= valid_i;
         for (int k = 1; k < N; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_i;
      for (int k = 1; k < N; k++) side_ff[k] <= side_ff[k-1];
      for (int k = 0; k < N; k++) begin
         val_ff[k] <= val_in[k];
         res_ff[k] <= res_in[k];
      end
   end

   assign valid_o = valid_ff[N-1];
   assign root_o  = res_ff[N-1][acs_pkg::ROOT_W-1:0];
   assign side_o  = side_ff[N-1];

endmodule

// File: design/acs_div.sv
module acs_div (
   input  logic                        clock,
   input  logic [acs_pkg::NUM_W-1:0]   num_i,
   input  logic [acs_pkg::DEN_W-1:0]   den_i,
   input  logic                        neg_i,
   output logic [acs_pkg::DATA_W-1:0]  quo_o,
   output logic                        sat_o
);

   localparam int QB = acs_pkg::Q_BITS;
   localparam int RW = acs_pkg::REM_W;
   localparam int DW = acs_pkg::DEN_W;
   localparam int NW = acs_pkg::NUM_W;
   localparam int OW = acs_pkg::DATA_W;

   logic [RW-1:0] rem_ff [0:QB];
   logic [DW-1:0] den_ff [0:QB];
   logic [QB-1:0] quo_ff [0:QB];
   logic          ovf_ff [0:QB];
   logic          neg_ff [0:QB];
   logic [RW:0]   diff   [1:QB];
   logic [OW-1:0] res_ff;
   logic          sat_ff;
   logic          sat_in;
   logic [OW-1:0] res_in;
   logic          ovf_in;

   assign ovf_in = (|num_i[NW-1:RW]) || (num_i[RW-1:0] >= {den_i, {QB{1'b0}}});

   always_comb begin
      for (int j = 1; j <= QB; j++) begin
         diff[j] = {1'b0, rem_ff[j-1]} - ({1'b0, RW'(den_ff[j-1])} << (QB - j));
      end
   end

   always_comb begin
      logic [QB-1:0] q;
      q = quo_ff[QB];
      if (neg_ff[QB]) begin
         sat_in = ovf_ff[QB] | q[QB-1] | (q[OW-1] & (|q[OW-2:0]));
         res_in = sat_in ? {1'b1, {(OW-1){1'b0}}} : OW'(~q[OW-1:0] + 1'b1);
      end else begin
         sat_in = ovf_ff[QB] | q[QB-1] | q[OW-1];
         res_in = sat_in ? {1'b0, {(OW-1){1'b1}}} : q[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_i[RW-1:0];
      den_ff[0] <= den_i;
      quo_ff[0] <= '0;
      ovf_ff[0] <= ovf_in;
      neg_ff[0] <= neg_i;
      for (int j = 1; j <= QB; j++) begin
         rem_ff[j] <= diff[j][RW] ? rem_ff[j-1] : diff[j][RW-1:0];
         quo_ff[j] <= {quo_ff[j-1][QB-2:0], ~diff[j][RW]};
         den_ff[j] <= den_ff[j-1];
         ovf_ff[j] <= ovf_ff[j-1];
         neg_ff[j] <= neg_ff[j-1];
      end
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign quo_o = res_ff;
   assign sat_o = sat_ff;

endmodule

// File: design/axisymmetric_capillary_source.sv
// Streaming capillary source kernel: one cell item may be started in every clock cycle and busy
// never rises. Each result appears on rsp with rsp_valid high for exactly one cycle, 80 cycles
// after the start transfer, and must be taken then, since the receiver cannot stall the block.
// The latency is set by four input stages, the 32-stage pipelined square root of the gradient
// norm, eight stages of split multiplications and the 35-stage pipelined restoring dividers,
// followed by the output register. Write sigma and the threshold only while no item is in flight.
module axisymmetric_capillary_source (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  acs_pkg::req_type                 req,
   output logic                             rsp_valid,
   output acs_pkg::rsp_type                 rsp,
   input  logic                             csr_we,
   input  logic [acs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [acs_pkg::DATA_W-1:0]       csr_wdata
);

   localparam int DW     = acs_pkg::DATA_W;
   localparam int PW     = acs_pkg::PROD_W;
   localparam int MW     = acs_pkg::MUL_W;
   localparam int EW     = acs_pkg::MUL_W + 1;
   localparam int HOLD_N = 6;
   localparam int FL_N   = acs_pkg::DIV_LAT;

   typedef struct packed {
      logic          func;
      logic          r_neg;
      logic          r_zero;
      logic [DW-1:0] r_mag;
      logic [DW-1:0] gx_mag;
      logic [DW-1:0] gy_mag;
      logic [DW-1:0] gz_mag;
      logic          gxy_neg;
      logic [DW-1:0] u_mag;
      logic          u_neg;
      logic [DW-1:0] v_mag;
      logic          v_neg;
   } p1_type;

   typedef struct packed {
      logic          func;
      logic          r_neg;
      logic          r_zero;
      logic [DW-1:0] r_mag;
      logic [PW-1:0] pxx;
      logic [PW-1:0] pxy;
      logic [PW-1:0] pyy;
      logic [PW-1:0] pzz;
      logic          gxy_neg;
      logic [DW-1:0] u_mag;
      logic          u_neg;
      logic [DW-1:0] v_mag;
      logic          v_neg;
   } p2_type;

   typedef struct packed {
      logic [PW-1:0]     sxy;
      logic [PW-1:0]     pzz;
      acs_pkg::side_type side;
   } p3_type;

   typedef struct packed {
      logic          applied;
      logic          r_zero;
      logic          r_neg;
      logic          neg_a;
      logic          neg_b;
      logic          ta_neg;
      logic          tb_neg;
      logic [PW-1:0] den;
   } t1_type;

   typedef struct packed {
      logic          applied;
      logic          r_zero;
      logic          r_neg;
      logic          neg_a;
      logic          neg_b;
      logic [PW-1:0] den;
      logic [MW-1:0] num_a;
      logic [MW-1:0] num_b;
   } hold_type;

   typedef struct packed {
      logic applied;
      logic r_zero;
   } flag_type;

   function automatic logic [DW-1:0] mag32(input logic [DW-1:0] x);
      mag32 = x[DW-1] ? (~x + 1'b1) : x;
   endfunction

   logic [DW-1:0]            sigma_ff;
   logic [acs_pkg::THR_W-1:0] thr_ff;

   logic              p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   p1_type            p1_ff;
   p1_type            p1_in;
   p2_type            p2_ff;
   p3_type            p3_ff;
   acs_pkg::side_type side_in;
   logic [PW-1:0]     rad_ff;
   acs_pkg::side_type p4_side_ff;

   logic              sq_valid;
   logic [DW-1:0]     sq_root;
   acs_pkg::side_type sq_side;

   logic              t1_valid_ff, t2_valid_ff;
   t1_type            t1_ff, t2_ff;
   logic [MW-1:0]     num_a, num_b, ta, tb, elo, ehi;
   logic [EW-1:0]     ta_s_ff, tb_s_ff, e_ff;
   logic [MW-1:0]     emag_ff;
   logic              eneg_ff [0:2];
   logic              neg_e_ff;
   logic [acs_pkg::NUM_W-1:0] num_e_ff;

   logic              hold_valid_ff [0:HOLD_N-1];
   hold_type          hold_ff       [0:HOLD_N-1];
   logic              fl_valid_ff   [0:FL_N-1];
   flag_type          fl_ff         [0:FL_N-1];

   logic [DW-1:0]     quo_x, quo_y, quo_e;
   logic              sat_x, sat_y, sat_e;

   logic              rsp_valid_ff;
   acs_pkg::rsp_type  rsp_ff;
   acs_pkg::rsp_type  rsp_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= '0;
         thr_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            acs_pkg::CSR_SIGMA:          sigma_ff <= csr_wdata;
            acs_pkg::CSR_NORM_THRESHOLD: thr_ff   <= csr_wdata[acs_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      p1_in.func    = req.func;
      p1_in.r_neg   = req.radius[DW-1];
      p1_in.r_zero  = (req.radius == '0);
      p1_in.r_mag   = mag32(req.radius);
      p1_in.gx_mag  = mag32(req.grad_x);
      p1_in.gy_mag  = mag32(req.grad_y);
      p1_in.gz_mag  = mag32(req.grad_z);
      p1_in.gxy_neg = req.grad_x[DW-1] ^ req.grad_y[DW-1];
      p1_in.u_mag   = mag32(req.vel_u);
      p1_in.u_neg   = req.vel_u[DW-1];
      p1_in.v_mag   = mag32(req.vel_v);
      p1_in.v_neg   = req.vel_v[DW-1];
   end

   always_comb begin
      side_in.a_mag  = p2_ff.func ? p2_ff.pxy : p2_ff.pxx;
      side_in.b_mag  = p2_ff.func ? p2_ff.pyy : p2_ff.pxy;
      side_in.a_neg  = p2_ff.func & p2_ff.gxy_neg;
      side_in.b_neg  = ~p2_ff.func & p2_ff.gxy_neg;
      side_in.ta_neg = (p2_ff.func & p2_ff.gxy_neg) ^ p2_ff.u_neg;
      side_in.tb_neg = (~p2_ff.func & p2_ff.gxy_neg) ^ p2_ff.v_neg;
      side_in.u_mag  = p2_ff.u_mag;
      side_in.v_mag  = p2_ff.v_mag;
      side_in.r_mag  = p2_ff.r_mag;
      side_in.r_neg  = p2_ff.r_neg;
      side_in.r_zero = p2_ff.r_zero;
   end

   always_ff @(posedge clock) begin
      p1_ff         <= p1_in;
      p2_ff.func    <= p1_ff.func;
      p2_ff.r_neg   <= p1_ff.r_neg;
      p2_ff.r_zero  <= p1_ff.r_zero;
      p2_ff.r_mag   <= p1_ff.r_mag;
      p2_ff.pxx     <= {{DW{1'b0}}, p1_ff.gx_mag} * {{DW{1'b0}}, p1_ff.gx_mag};
      p2_ff.pxy     <= {{DW{1'b0}}, p1_ff.gx_mag} * {{DW{1'b0}}, p1_ff.gy_mag};
      p2_ff.pyy     <= {{DW{1'b0}}, p1_ff.gy_mag} * {{DW{1'b0}}, p1_ff.gy_mag};
      p2_ff.pzz     <= {{DW{1'b0}}, p1_ff.gz_mag} * {{DW{1'b0}}, p1_ff.gz_mag};
      p2_ff.gxy_neg <= p1_ff.gxy_neg;
      p2_ff.u_mag   <= p1_ff.u_mag;
      p2_ff.u_neg   <= p1_ff.u_neg;
      p2_ff.v_mag   <= p1_ff.v_mag;
      p2_ff.v_neg   <= p1_ff.v_neg;
      p3_ff.sxy     <= p2_ff.pxx + p2_ff.pyy;
      p3_ff.pzz     <= p2_ff.pzz;
      p3_ff.side    <= side_in;
      rad_ff        <= p3_ff.sxy + p3_ff.pzz;
      p4_side_ff    <= p3_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= start & ~busy;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   acs_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .valid_i (p4_valid_ff),
      .rad_i   (rad_ff),
      .side_i  (p4_side_ff),
      .valid_o (sq_valid),
      .root_o  (sq_root),
      .side_o  (sq_side)
   );

   acs_mul u_mul_as (.clock(clock), .a_i(sq_side.a_mag), .b_i(sigma_ff), .prod_o(num_a));
   acs_mul u_mul_bs (.clock(clock), .a_i(sq_side.b_mag), .b_i(sigma_ff), .prod_o(num_b));
   acs_mul u_mul_au (.clock(clock), .a_i(sq_side.a_mag), .b_i(sq_side.u_mag), .prod_o(ta));
   acs_mul u_mul_bv (.clock(clock), .a_i(sq_side.b_mag), .b_i(sq_side.v_mag), .prod_o(tb));

   always_ff @(posedge clock) begin
      t1_ff.applied <= sq_root > {1'b0, thr_ff};
      t1_ff.r_zero  <= sq_side.r_zero;
      t1_ff.r_neg   <= sq_side.r_neg;
      t1_ff.neg_a   <= sq_side.a_neg == sq_side.r_neg;
      t1_ff.neg_b   <= sq_side.b_neg == sq_side.r_neg;
      t1_ff.ta_neg  <= sq_side.ta_neg;
      t1_ff.tb_neg  <= sq_side.tb_neg;
      t1_ff.den     <= {{DW{1'b0}}, sq_root} * {{DW{1'b0}}, sq_side.r_mag};
      t2_ff         <= t1_ff;

      ta_s_ff <= t2_ff.ta_neg ? (EW'(0) - {1'b0, ta}) : {1'b0, ta};
      tb_s_ff <= t2_ff.tb_neg ? (EW'(0) - {1'b0, tb}) : {1'b0, tb};
      hold_ff[0].applied <= t2_ff.applied;
      hold_ff[0].r_zero  <= t2_ff.r_zero;
      hold_ff[0].r_neg   <= t2_ff.r_neg;
      hold_ff[0].neg_a   <= t2_ff.neg_a;
      hold_ff[0].neg_b   <= t2_ff.neg_b;
      hold_ff[0].den     <= t2_ff.den;
      hold_ff[0].num_a   <= num_a;
      hold_ff[0].num_b   <= num_b;
      for (int i = 1; i < HOLD_N; i++) hold_ff[i] <= hold_ff[i-1];

      e_ff       <= ta_s_ff + tb_s_ff;
      emag_ff    <= e_ff[EW-1] ? MW'(EW'(0) - e_ff) : e_ff[MW-1:0];
      eneg_ff[0] <= e_ff[EW-1];
      eneg_ff[1] <= eneg_ff[0];
      eneg_ff[2] <= eneg_ff[1];
      neg_e_ff   <= eneg_ff[2] == hold_ff[HOLD_N-2].r_neg;
      num_e_ff   <= {{DW{1'b0}}, elo} + {ehi[PW-1:0], {PW{1'b0}}};
   end

   acs_mul u_mul_elo (.clock(clock), .a_i(emag_ff[PW-1:0]), .b_i(sigma_ff), .prod_o(elo));
   acs_mul u_mul_ehi (.clock(clock), .a_i(PW'(emag_ff[MW-1:PW])), .b_i(sigma_ff),
                      .prod_o(ehi));

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         for (int i = 0; i < HOLD_N; i++) hold_valid_ff[i] <= 1'b0;
      end else begin
         t1_valid_ff      <= sq_valid;
         t2_valid_ff      <= t1_valid_ff;
         hold_valid_ff[0] <= t2_valid_ff;
         for (int i = 1; i < HOLD_N; i++) hold_valid_ff[i] <= hold_valid_ff[i-1];
      end
   end

   acs_div u_div_x (
      .clock (clock),
      .num_i (acs_pkg::NUM_W'(hold_ff[HOLD_N-1].num_a)),
      .den_i (acs_pkg::DEN_W'(hold_ff[HOLD_N-1].den)),
      .neg_i (hold_ff[HOLD_N-1].neg_a),
      .quo_o (quo_x),
      .sat_o (sat_x)
   );

   acs_div u_div_y (
      .clock (clock),
      .num_i (acs_pkg::NUM_W'(hold_ff[HOLD_N-1].num_b)),
      .den_i (acs_pkg::DEN_W'(hold_ff[HOLD_N-1].den)),
      .neg_i (hold_ff[HOLD_N-1].neg_b),
      .quo_o (quo_y),
      .sat_o (sat_y)
   );

   acs_div u_div_e (
      .clock (clock),
      .num_i (num_e_ff),
      .den_i ({hold_ff[HOLD_N-1].den, {acs_pkg::FRAC_BITS{1'b0}}}),
      .neg_i (neg_e_ff),
      .quo_o (quo_e),
      .sat_o (sat_e)
   );

   always_ff @(posedge clock) begin
      fl_ff[0].applied <= hold_ff[HOLD_N-1].applied;
      fl_ff[0].r_zero  <= hold_ff[HOLD_N-1].r_zero;
      for (int i = 1; i < FL_N; i++) fl_ff[i] <= fl_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FL_N; i++) fl_valid_ff[i] <= 1'b0;
      end else begin
         fl_valid_ff[0] <= hold_valid_ff[HOLD_N-1];
         for (int i = 1; i < FL_N; i++) fl_valid_ff[i] <= fl_valid_ff[i-1];
      end
   end

   always_comb begin
      rsp_in = '0;
      if (fl_ff[FL_N-1].applied) begin
         rsp_in.applied = 1'b1;
         if (fl_ff[FL_N-1].r_zero) begin
            rsp_in.saturated = 1'b1;
         end else begin
            rsp_in.mom_x     = quo_x;
            rsp_in.mom_y     = quo_y;
            rsp_in.energy    = quo_e;
            rsp_in.saturated = sat_x | sat_y | sat_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fl_valid_ff[FL_N-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [acs_pkg::CSR_IDX_W-1:0] CSR_UNUSED = acs_pkg::CSR_IDX_W'(2);
   localparam int IDLE_LIMIT = 2000;

   class capillary_scoreboard;
      logic [acs_pkg::DATA_W-1:0] sigma;
      logic [acs_pkg::THR_W-1:0]  threshold;
      acs_pkg::rsp_type           awaited[$];
      int                         errors;

      function new();
         sigma = '0;
         threshold = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [acs_pkg::CSR_IDX_W-1:0] idx,
                              logic [acs_pkg::DATA_W-1:0] val);
         if (idx == acs_pkg::CSR_SIGMA) sigma = val;
         else if (idx == acs_pkg::CSR_NORM_THRESHOLD) threshold = val[acs_pkg::THR_W-1:0];
      endfunction

      function logic [acs_pkg::DATA_W-1:0] clip(bit neg, logic [127:0] num, logic [127:0] den,
                                                inout bit sat);
         logic [127:0] q;
         q = num / den;
         if (!neg) begin
            if (q > 128'h7FFF_FFFF) begin
               sat = 1'b1;
               return 32'h7FFF_FFFF;
            end
            return q[31:0];
         end
         if (q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
         end
         return -q[31:0];
      endfunction

      function acs_pkg::rsp_type source_terms(acs_pkg::req_type x);
         acs_pkg::rsp_type res;
         logic signed [63:0] r, gx, gy, gz, u, v, a, b;
         logic [63:0] mx, my, mz, sq, norm, bitv, am, bm, um, vm, rm;
         logic signed [127:0] ta, tb, e;
         logic [127:0] den, emag, sig;
         bit sat, rneg, eneg;
         r = x.radius; gx = x.grad_x; gy = x.grad_y; gz = x.grad_z;
         u = x.vel_u; v = x.vel_v;
         mx = gx < 0 ? -gx : gx;
         my = gy < 0 ? -gy : gy;
         mz = gz < 0 ? -gz : gz;
         sq = mx * mx + my * my + mz * mz;
         norm = 0;
         bitv = 64'd1 << 62;
         while (bitv > sq) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (sq >= norm + bitv) begin
               sq = sq - (norm + bitv);
               norm = (norm >> 1) + bitv;
            end else begin
               norm = norm >> 1;
            end
            bitv = bitv >> 2;
         end
         res = '0;
         sat = 1'b0;
         if (norm > {33'b0, threshold}) begin
            res.applied = 1'b1;
            if (r == 0) begin
               sat = 1'b1;
            end else begin
               a = x.func ? gx * gy : gx * gx;
               b = x.func ? gy * gy : gx * gy;
               am = a < 0 ? -a : a;
               bm = b < 0 ? -b : b;
               um = u < 0 ? -u : u;
               vm = v < 0 ? -v : v;
               rm = r < 0 ? -r : r;
               rneg = r < 0;
               sig = {96'b0, sigma};
               den = {64'b0, norm * rm};
               res.mom_x = clip((a < 0) == rneg, {64'b0, am} * sig, den, sat);
               res.mom_y = clip((b < 0) == rneg, {64'b0, bm} * sig, den, sat);
               ta = $signed({64'b0, am} * {64'b0, um});
               if ((a < 0) != (u < 0)) ta = -ta;
               tb = $signed({64'b0, bm} * {64'b0, vm});
               if ((b < 0) != (v < 0)) tb = -tb;
               e = ta + tb;
               eneg = e < 0;
               emag = eneg ? -e : e;
               res.energy = clip(eneg == rneg, emag * sig, den << acs_pkg::FRAC_BITS, sat);
            end
         end
         res.saturated = sat;
         return res;
      endfunction

      function void note(acs_pkg::req_type x);
         awaited.insert(awaited.size(), source_terms(x));
      endfunction

      function void check(acs_pkg::rsp_type got);
         acs_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.mom_x !== want.mom_x) begin
            $error("mom_x expected %0d actual %0d", want.mom_x, got.mom_x);
            errors++;
         end
         if (got.mom_y !== want.mom_y) begin
            $error("mom_y expected %0d actual %0d", want.mom_y, got.mom_y);
            errors++;
         end
         if (got.energy !== want.energy) begin
            $error("energy expected %0d actual %0d", want.energy, got.energy);
            errors++;
         end
         if (got.applied !== want.applied) begin
            $error("applied expected %0d actual %0d", want.applied, got.applied);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated expected %0d actual %0d", want.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          start = 0;
   logic                          busy;
   acs_pkg::req_type              req = '0;
   logic                          rsp_valid;
   acs_pkg::rsp_type              rsp;
   logic                          csr_we = 0;
   logic [acs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [acs_pkg::DATA_W-1:0]    csr_wdata = '0;

   capillary_scoreboard sb = new();
   int idle_cycles = 0;

   axisymmetric_capillary_source dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note(req);
         if (rsp_valid) sb.check(rsp);
      end
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL axisymmetric_capillary_source");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [acs_pkg::CSR_IDX_W-1:0] idx,
                            logic [acs_pkg::DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic send_item(acs_pkg::req_type x);
      @(negedge clock);
      start <= 1'b1;
      req <= x;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   task automatic pause(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      pause(0);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
         3: return 32'($signed($urandom_range(0, 510)) - 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic acs_pkg::req_type random_item();
      acs_pkg::req_type x;
      x.func = 1'($urandom_range(0, 1));
      x.radius = pick_word();
      x.grad_x = pick_word();
      x.grad_y = pick_word();
      x.grad_z = pick_word();
      x.vel_u = pick_word();
      x.vel_v = pick_word();
      return x;
   endfunction

   function automatic acs_pkg::req_type make_item(logic f, logic [31:0] r, logic [31:0] gx,
                                                  logic [31:0] gy, logic [31:0] gz,
                                                  logic [31:0] u, logic [31:0] v);
      acs_pkg::req_type x;
      x.func = f; x.radius = r; x.grad_x = gx; x.grad_y = gy; x.grad_z = gz;
      x.vel_u = u; x.vel_v = v;
      return x;
   endfunction

   logic [31:0] sigmas[7] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000,
                              32'h0, 32'h0, 32'h0001_8000};
   logic [31:0] limits[7] = '{32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF,
                              32'h0, 32'h0, 32'h0001_0000};

   initial begin
      int burst;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_reg(acs_pkg::CSR_SIGMA, 32'h0001_0000);
      write_reg(acs_pkg::CSR_NORM_THRESHOLD, 32'h0);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);

      send_item(make_item(0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 0));
      send_item(make_item(1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000,
                          32'hFFFE_0000, 32'h0003_0000));
      send_item(make_item(0, 32'h0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
      send_item(make_item(1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
      send_item(make_item(0, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_item(make_item(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000));
      send_item(make_item(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                          32'h8000_0000, 32'h7FFF_FFFF));
      send_item(make_item(1, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h1));
      send_item(make_item(0, 32'h0, 32'h0, 32'h0, 32'h5, 32'h0, 32'h0));
      send_item(make_item(1, 32'hFFF0_0000, 32'h0, 32'h0100_0000, 32'h0, 32'h1234_5678,
                          32'hEDCB_A988));
      drain();
      write_reg(acs_pkg::CSR_NORM_THRESHOLD, 32'h0002_0000);
      send_item(make_item(0, 32'h0, 32'h0001_0000, 32'h0, 0, 0, 0));
      send_item(make_item(0, 32'h0001_0000, 32'h0002_0000, 32'h0, 0, 32'h0001_0000, 0));
      send_item(make_item(1, 32'h0001_0000, 32'h0002_0001, 32'h0, 0, 32'h0001_0000, 0));
      send_item(make_item(0, 32'h0, 32'h0003_0000, 32'h0, 0, 0, 0));

      for (int phase = 0; phase < 7; phase++) begin
         drain();
         if (phase == 4) begin
            write_reg(acs_pkg::CSR_SIGMA, $urandom);
            write_reg(acs_pkg::CSR_NORM_THRESHOLD, $urandom_range(0, 2 ** 20));
         end else if (phase == 5) begin
            write_reg(acs_pkg::CSR_SIGMA, $urandom);
            write_reg(acs_pkg::CSR_NORM_THRESHOLD, {1'b0, 31'($urandom)});
         end else begin
            write_reg(acs_pkg::CSR_SIGMA, sigmas[phase]);
            write_reg(acs_pkg::CSR_NORM_THRESHOLD, limits[phase]);
         end
         for (int n = 0; n < 260; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < 260; k++, n++) send_item(random_item());
            if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 10));
         end
      end
      drain();
      if (sb.awaited.size() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("PASS axisymmetric_capillary_source");
      end else begin
         $display("FAIL axisymmetric_capillary_source");
      end
      $finish;
   end
endmodule

// File: axisymmetric_capillary_source.f
design/acs_pkg.sv
design/acs_mul.sv
design/acs_sqrt.sv
design/acs_div.sv
design/axisymmetric_capillary_source.sv
verif/testbench.sv
